// ----- sv/assert_macros.svh -----
// assertion macros for the frustum cull rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked on clock, off while reset is high
`define ASSERT_CLK(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("frustum cull assertion failed");

// clocked on clock, checked through reset as well
`define ASSERT_CLK_NORST(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("frustum cull assertion failed");

`endif

// ----- sv/fcull_pkg.sv -----
// types, constants and codes for the frustum cull block
package fcull_pkg;

   localparam int PLANE_COUNT = 6;
   localparam int FRAC_BITS   = 16;
   localparam int COORD_WIDTH = 32;

   localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
   localparam int UPROD_WIDTH = 2 * COORD_WIDTH - 1;
   // three signed products, offset, three unsigned products, radius: 3 guard bits
   localparam int SUM_WIDTH   = 2 * COORD_WIDTH + 3;

   localparam logic [1:0] ACT_LOAD   = 2'd0;
   localparam logic [1:0] ACT_SPHERE = 2'd1;
   localparam logic [1:0] ACT_BOX    = 2'd2;

   localparam logic [2:0] NO_PLANE = 3'd6;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic [COORD_WIDTH-2:0]        ucoord_type;

   typedef struct packed {
      logic [1:0]         action;
      logic [2:0]         plane_index;
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic signed [31:0] vec_z;
      logic signed [31:0] plane_offset;
      logic [30:0]        half_x;
      logic [30:0]        half_y;
      logic [30:0]        half_z;
      logic [30:0]        radius;
   } req_type;

   typedef struct packed {
      logic       visible;
      logic [2:0] rejecting_plane;
   } rsp_type;

   typedef struct packed {
      coord_type nx;
      coord_type ny;
      coord_type nz;
      coord_type w;
   } plane_type;

   typedef struct packed {
      coord_type  cx;
      coord_type  cy;
      coord_type  cz;
      ucoord_type hx;
      ucoord_type hy;
      ucoord_type hz;
      logic       box;
   } lane_in_type;

endpackage

// ----- sv/frustum_cull_test_top.sv -----
// top level of the frustum cull block: pipeline, flow control, result encode
//
// Holds six Q16.16 planes and, while not stalled, tests one sphere or box per
// cycle against all of them at once. A beat on req_ either loads a plane
// (action load) or tests a volume (sphere or box); every beat yields exactly
// one rsp_ beat, in order. Throughput is one beat per clock unless rsp_stall
// backs up the pipeline. A result passes the input, product and result
// registers in turn; the product register splits each lane's 32x32 and 32x31
// multipliers from its wide sum. A plane load is seen by the very next beat.
// Sums are exact, so no rounding or overflow ever enters the decision. Loads
// and unused action codes return visible 0 with rejecting_plane 6; a test
// that no plane rejects returns visible 1 with rejecting_plane 6.
`include "assert_macros.svh"

module frustum_cull_test_top import fcull_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic adv1, adv2, adv3;

   logic       s1_v_ff;
   req_type    s1_data_ff;
   logic       s2_v_ff;
   logic [1:0] s2_action_ff;
   ucoord_type s2_radius_ff;
   ucoord_type s2_radius_in;
   logic       rsp_valid_ff;
   rsp_type    rsp_data_ff;
   rsp_type    rsp_data_in;

   plane_type [PLANE_COUNT-1:0] planes;
   plane_type                   load_plane;
   lane_in_type                 lane_item;
   logic                        plane_we;
   logic [PLANE_COUNT-1:0]      reject;

   // each stage moves when the one after it is empty or moving
   assign adv3 = !rsp_valid_ff || !rsp_stall;
   assign adv2 = !s2_v_ff || adv3;
   assign adv1 = !s1_v_ff || adv2;
   assign req_stall = !adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv1) begin
            s1_v_ff <= req_valid;
         end
         if (adv2) begin
            s2_v_ff <= s1_v_ff;
         end
         if (adv3) begin
            rsp_valid_ff <= s2_v_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_data_ff <= req_data;
      end
      if (adv2) begin
         s2_action_ff <= s1_data_ff.action;
         s2_radius_ff <= s2_radius_in;
      end
      if (adv3) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign s2_radius_in = (s1_data_ff.action == ACT_SPHERE) ?
                         s1_data_ff.radius[COORD_WIDTH-2:0] : '0;

   // load writes as its beat leaves the input register, so later beats see it
   assign plane_we = s1_v_ff && adv2 && (s1_data_ff.action == ACT_LOAD);

   assign load_plane.nx = signed'(s1_data_ff.vec_x[COORD_WIDTH-1:0]);
   assign load_plane.ny = signed'(s1_data_ff.vec_y[COORD_WIDTH-1:0]);
   assign load_plane.nz = signed'(s1_data_ff.vec_z[COORD_WIDTH-1:0]);
   assign load_plane.w  = signed'(s1_data_ff.plane_offset[COORD_WIDTH-1:0]);

   assign lane_item.cx  = signed'(s1_data_ff.vec_x[COORD_WIDTH-1:0]);
   assign lane_item.cy  = signed'(s1_data_ff.vec_y[COORD_WIDTH-1:0]);
   assign lane_item.cz  = signed'(s1_data_ff.vec_z[COORD_WIDTH-1:0]);
   assign lane_item.hx  = s1_data_ff.half_x[COORD_WIDTH-2:0];
   assign lane_item.hy  = s1_data_ff.half_y[COORD_WIDTH-2:0];
   assign lane_item.hz  = s1_data_ff.half_z[COORD_WIDTH-2:0];
   assign lane_item.box = (s1_data_ff.action == ACT_BOX);

   fcull_plane_store u_store (
      .clock       (clock),
      .reset       (reset),
      .write_en    (plane_we),
      .write_index (s1_data_ff.plane_index),
      .write_plane (load_plane),
      .planes      (planes)
   );

   for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_lane
      fcull_lane u_lane (
         .clock       (clock),
         .enable      (adv2),
         .plane       (planes[p]),
         .item        (lane_item),
         .radius_term (s2_radius_ff),
         .reject      (reject[p])
      );
   end

   // lowest rejecting plane wins
   always_comb begin
      rsp_data_in.visible         = 1'b0;
      rsp_data_in.rejecting_plane = NO_PLANE;
      case (s2_action_ff)
         ACT_SPHERE, ACT_BOX: begin
            for (int p = PLANE_COUNT - 1; p >= 0; p--) begin
               if (reject[p]) begin
                  rsp_data_in.rejecting_plane = 3'(p);
               end
            end
            rsp_data_in.visible = (reject == '0);
         end
         default: begin
            rsp_data_in.visible         = 1'b0;
            rsp_data_in.rejecting_plane = NO_PLANE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_CLK(a_visible_no_plane,
      rsp_valid && rsp_data.visible |-> rsp_data.rejecting_plane == NO_PLANE)
   `ASSERT_CLK(a_plane_in_range,
      rsp_valid |-> rsp_data.rejecting_plane < 3'(PLANE_COUNT) ||
                    rsp_data.rejecting_plane == NO_PLANE)
   `ASSERT_CLK(a_stall_only_when_full,
      req_stall |-> s1_v_ff && s2_v_ff && rsp_valid && rsp_stall)
   `ASSERT_CLK_NORST(a_empty_after_reset, $past(reset) |-> !rsp_valid)

endmodule

// ----- sv/fcull_plane_store.sv -----
// register file holding the frustum planes
module fcull_plane_store import fcull_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        write_en,
   input  logic [2:0]                  write_index,
   input  plane_type                   write_plane,
   output plane_type [PLANE_COUNT-1:0] planes
);

   plane_type [PLANE_COUNT-1:0] planes_ff;

   // an index past the last plane matches no entry and writes nothing
   always_ff @(posedge clock) begin
      if (reset) begin
         planes_ff <= '0;
      end else begin
         for (int p = 0; p < PLANE_COUNT; p++) begin
            if (write_en && write_index == 3'(p)) begin
               planes_ff[p] <= write_plane;
            end
         end
      end
   end

   assign planes = planes_ff;

endmodule

// ----- sv/fcull_lane.sv -----
// one plane lane: registered products, then the signed sum and its sign
module fcull_lane import fcull_pkg::*; (
   input  logic        clock,
   input  logic        enable,
   input  plane_type   plane,
   input  lane_in_type item,
   input  ucoord_type  radius_term,
   output logic        reject
);

   logic [COORD_WIDTH-1:0] ax, ay, az;

   logic signed [PROD_WIDTH-1:0] px_in, py_in, pz_in;
   logic signed [PROD_WIDTH-1:0] px_ff, py_ff, pz_ff;
   logic [UPROD_WIDTH-1:0]       qx_in, qy_in, qz_in;
   logic [UPROD_WIDTH-1:0]       qx_ff, qy_ff, qz_ff;
   coord_type                    w_ff;
   logic signed [SUM_WIDTH-1:0]  sum;

   // magnitude of the most negative normal still fits unsigned
   assign ax = plane.nx[COORD_WIDTH-1] ? COORD_WIDTH'(-plane.nx) : COORD_WIDTH'(plane.nx);
   assign ay = plane.ny[COORD_WIDTH-1] ? COORD_WIDTH'(-plane.ny) : COORD_WIDTH'(plane.ny);
   assign az = plane.nz[COORD_WIDTH-1] ? COORD_WIDTH'(-plane.nz) : COORD_WIDTH'(plane.nz);

   assign px_in = plane.nx * item.cx;
   assign py_in = plane.ny * item.cy;
   assign pz_in = plane.nz * item.cz;

   // positive-vertex terms only for boxes
   assign qx_in = item.box ? ax * item.hx : '0;
   assign qy_in = item.box ? ay * item.hy : '0;
   assign qz_in = item.box ? az * item.hz : '0;

   always_ff @(posedge clock) begin
      if (enable) begin
         px_ff <= px_in;
         py_ff <= py_in;
         pz_ff <= pz_in;
         qx_ff <= qx_in;
         qy_ff <= qy_in;
         qz_ff <= qz_in;
         w_ff  <= plane.w;
      end
   end

   assign sum = SUM_WIDTH'(px_ff) + SUM_WIDTH'(py_ff) + SUM_WIDTH'(pz_ff)
              + (SUM_WIDTH'(w_ff) <<< FRAC_BITS)
              + signed'(SUM_WIDTH'(qx_ff)) + signed'(SUM_WIDTH'(qy_ff))
              + signed'(SUM_WIDTH'(qz_ff))
              + signed'(SUM_WIDTH'(radius_term) << FRAC_BITS);

   // exactly zero is on the plane, not behind it
   assign reject = sum[SUM_WIDTH-1];

endmodule
